FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");
// Implication with the consequent checked in the next cycle.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");
`endif

FILE: sv/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager package
// Shared constants, command and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package bpfm_pkg;

    localparam int DEF_FRAMES    = 16;
    localparam int DEF_PAGE_BITS = 16;

    localparam logic [2:0] CMD_PIN      = 3'd0;
    localparam logic [2:0] CMD_UNPIN    = 3'd1;
    localparam logic [2:0] CMD_DIRTY    = 3'd2;
    localparam logic [2:0] CMD_FORCE    = 3'd3;
    localparam logic [2:0] CMD_FLUSH    = 3'd4;
    localparam logic [2:0] CMD_SHUTDOWN = 3'd5;
    localparam logic [2:0] CMD_QUERY    = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RES   = 3'd1;
    localparam logic [2:0] ST_UNPIN0    = 3'd2;
    localparam logic [2:0] ST_ALL_PIN   = 3'd3;
    localparam logic [2:0] ST_IN_USE    = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic search;    // capture command and run the frame search
        logic execute;   // apply the single-result command
        logic scan_clr;  // reset the flush scan pointer
        logic scan_step; // examine the frame at the scan pointer
        logic wipe;      // empty every frame after shutdown
        logic emit_end;  // produce the closing result of flush or shutdown
    } bpfm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_multi;   // command is flush, or shutdown with no pinned frame
        logic scan_done;  // scan pointer has passed the last frame in use
        logic scan_hit;   // frame at the scan pointer needs a write-back
        logic is_shut;    // captured command is shutdown
    } bpfm_sts_t;

endpackage

FILE: sv/bpfm_ctrl.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager controller
// Sequences search, execute, the flush and shutdown scan and the wipe; drives the output handshake.
// ----------------------------------------------------------------------------
module bpfm_ctrl
    import bpfm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_free,
    input  bpfm_sts_t sts,
    output logic      in_ready,
    output logic      out_load,
    output bpfm_cmd_t cmd
);

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SCAN, S_WIPE, S_END} state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.search = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.is_multi)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
                else if (out_free)
                begin
                    cmd.execute = 1'b1;
                    out_load    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.is_shut ? S_WIPE : S_END;
                end
                else if (!sts.scan_hit)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.scan_step = 1'b1;
                    out_load      = 1'b1;
                end
            end
            S_WIPE:
            begin
                cmd.wipe   = 1'b1;
                state_next = S_END;
            end
            S_END:
            begin
                if (out_free)
                begin
                    cmd.emit_end = 1'b1;
                    out_load     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/bpfm_datapath.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager datapath
// Frame table, registered search results, counters and result formatting.
// ----------------------------------------------------------------------------
module bpfm_datapath
    import bpfm_pkg::*;
#(
    parameter int FRAMES    = DEF_FRAMES,
    parameter int PAGE_BITS = DEF_PAGE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  frames_in_use,
    input  logic [2:0]  in_command,
    input  logic [15:0] in_page,
    input  logic [3:0]  in_select,
    input  bpfm_cmd_t   cmd,
    output bpfm_sts_t   sts,
    output logic [2:0]  r_status,
    output logic [3:0]  r_index,
    output logic [15:0] r_page,
    output logic        r_valid,
    output logic        r_dirty,
    output logic [7:0]  r_pins,
    output logic        r_read,
    output logic        r_write,
    output logic [15:0] r_wb_page,
    output logic [31:0] r_reads,
    output logic [31:0] r_writes,
    output logic        r_last
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0] page_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg, dirty_reg;
    logic [7:0]           pins_reg [FRAMES];
    logic [FW-1:0]        order_reg [FRAMES];
    logic [31:0]          reads_reg, writes_reg;

    logic [2:0]           c_cmd_reg;
    logic [PAGE_BITS-1:0] c_page_reg;
    logic [3:0]           c_sel_reg;
    logic                 hit_reg, empty_reg, vict_reg, pinned_reg;
    logic [FW-1:0]        hit_idx_reg, empty_idx_reg, vict_idx_reg, pinned_idx_reg;
    logic [NW-1:0]        n_reg;
    logic [NW-1:0]        scan_reg;

    // Clamp of the pool size.
    logic [NW-1:0] n_val;
    always_comb
    begin
        if (frames_in_use == 5'd0)
            n_val = NW'(1);
        else if (32'(frames_in_use) > FRAMES)
            n_val = NW'(FRAMES);
        else
            n_val = NW'(frames_in_use);
    end

    // Frame search on the incoming item: hit, lowest empty, oldest unpinned, lowest pinned.
    // The oldest unpinned frame is found by comparing all candidate pairs at once.
    logic [PAGE_BITS-1:0] pg_in;
    logic                 s_hit, s_empty, s_vict, s_pin;
    logic [FW-1:0]        s_hit_i, s_empty_i, s_vict_i, s_pin_i;
    logic [FRAMES-1:0]    v_cand, v_best;
    always_comb
    begin
        pg_in   = PAGE_BITS'(in_page);
        s_hit   = 1'b0; s_empty = 1'b0; s_vict = 1'b0; s_pin = 1'b0;
        s_hit_i = '0; s_empty_i = '0; s_vict_i = '0; s_pin_i = '0;
        for (int f = FRAMES - 1; f >= 0; f--)
        begin
            if (NW'(f) < n_val)
            begin
                if (valid_reg[f] && page_reg[f] == pg_in)
                begin
                    s_hit = 1'b1; s_hit_i = FW'(f);
                end
                if (!valid_reg[f])
                begin
                    s_empty = 1'b1; s_empty_i = FW'(f);
                end
                if (pins_reg[f] != 8'd0)
                begin
                    s_pin = 1'b1; s_pin_i = FW'(f);
                end
            end
        end
        for (int f = 0; f < FRAMES; f++)
            v_cand[f] = (NW'(f) < n_val) && (pins_reg[f] == 8'd0);
        for (int f = 0; f < FRAMES; f++)
        begin
            v_best[f] = v_cand[f];
            for (int g = 0; g < FRAMES; g++)
                if (g != f && v_cand[g] &&
                    (order_reg[g] > order_reg[f] ||
                     (order_reg[g] == order_reg[f] && g < f)))
                    v_best[f] = 1'b0;
        end
        for (int f = FRAMES - 1; f >= 0; f--)
        begin
            if (v_best[f])
            begin
                s_vict = 1'b1; s_vict_i = FW'(f);
            end
        end
    end

    // Status toward the controller.
    logic [FW-1:0] scan_idx;
    assign scan_idx       = scan_reg[FW-1:0];
    assign sts.is_shut    = (c_cmd_reg == CMD_SHUTDOWN);
    assign sts.is_multi   = (c_cmd_reg == CMD_FLUSH) ||
                            (c_cmd_reg == CMD_SHUTDOWN && !pinned_reg);
    assign sts.scan_done  = (scan_reg >= n_reg);
    assign sts.scan_hit   = valid_reg[scan_idx] && dirty_reg[scan_idx] &&
                            pins_reg[scan_idx] == 8'd0;

    // Decision for single-result commands.
    logic          d_sel;
    logic [FW-1:0] d_idx;
    logic [2:0]    d_st;
    logic          d_rd, d_wr, d_load, d_ok;
    logic [PAGE_BITS-1:0] d_wb;
    always_comb
    begin
        d_sel = 1'b0; d_idx = '0; d_st = ST_OK; d_rd = 1'b0; d_wr = 1'b0;
        d_load = 1'b0; d_ok = 1'b0; d_wb = '0;
        unique case (c_cmd_reg)
            CMD_PIN:
            begin
                if (hit_reg)
                begin
                    d_sel = 1'b1; d_idx = hit_idx_reg;
                    if (pins_reg[hit_idx_reg] == 8'hFF) d_st = ST_OVERFLOW;
                    else d_ok = 1'b1;
                end
                else if (empty_reg)
                begin
                    d_sel = 1'b1; d_idx = empty_idx_reg; d_rd = 1'b1; d_load = 1'b1;
                end
                else if (vict_reg)
                begin
                    d_sel = 1'b1; d_idx = vict_idx_reg; d_rd = 1'b1; d_load = 1'b1;
                    d_wr = dirty_reg[vict_idx_reg]; d_wb = page_reg[vict_idx_reg];
                end
                else
                    d_st = ST_ALL_PIN;
            end
            CMD_UNPIN, CMD_DIRTY, CMD_FORCE:
            begin
                if (!hit_reg)
                    d_st = ST_NOT_RES;
                else
                begin
                    d_sel = 1'b1; d_idx = hit_idx_reg;
                    if (c_cmd_reg == CMD_UNPIN && pins_reg[hit_idx_reg] == 8'd0)
                        d_st = ST_UNPIN0;
                    else
                        d_ok = 1'b1;
                    if (c_cmd_reg == CMD_FORCE)
                    begin
                        d_wr = 1'b1; d_wb = page_reg[hit_idx_reg];
                    end
                end
            end
            CMD_SHUTDOWN:
            begin
                d_sel = 1'b1; d_idx = pinned_idx_reg; d_st = ST_IN_USE;
            end
            CMD_QUERY:
            begin
                if (32'(c_sel_reg) < FRAMES)
                begin
                    d_sel = 1'b1; d_idx = FW'(c_sel_reg);
                end
            end
            default: d_sel = 1'b0;
        endcase
    end

    // Frame contents after the step for the reported frame.
    logic [PAGE_BITS-1:0] nx_page;
    logic                 nx_valid, nx_dirty;
    logic [7:0]           nx_pins;
    always_comb
    begin
        nx_page  = page_reg[d_idx];
        nx_valid = valid_reg[d_idx];
        nx_dirty = dirty_reg[d_idx];
        nx_pins  = pins_reg[d_idx];
        if (d_load)
        begin
            nx_page = c_page_reg; nx_valid = 1'b1; nx_dirty = 1'b0; nx_pins = 8'd1;
        end
        else if (d_ok)
        begin
            unique case (c_cmd_reg)
                CMD_PIN:   nx_pins = pins_reg[d_idx] + 8'd1;
                CMD_UNPIN: nx_pins = pins_reg[d_idx] - 8'd1;
                CMD_DIRTY: nx_dirty = 1'b1;
                CMD_FORCE: nx_dirty = (pins_reg[d_idx] == 8'd0) ? 1'b0 : dirty_reg[d_idx];
                default:   nx_pins = pins_reg[d_idx];
            endcase
        end
    end

    // Frame table, search registers and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            reads_reg  <= '0;
            writes_reg <= '0;
            scan_reg   <= '0;
            for (int f = 0; f < FRAMES; f++)
            begin
                page_reg[f]  <= '0;
                pins_reg[f]  <= '0;
                order_reg[f] <= '0;
            end
        end
        else
        begin
            if (cmd.execute)
            begin
                page_reg[d_idx]  <= nx_page;
                valid_reg[d_idx] <= nx_valid;
                dirty_reg[d_idx] <= nx_dirty;
                pins_reg[d_idx]  <= nx_pins;
                if (d_rd)  reads_reg  <= reads_reg + 32'd1;
                if (d_wr)  writes_reg <= writes_reg + 32'd1;
                if (d_load)
                begin
                    for (int g = 0; g < FRAMES; g++)
                        if (FW'(g) != d_idx && valid_reg[g] &&
                            (!valid_reg[d_idx] || order_reg[g] < order_reg[d_idx]))
                            order_reg[g] <= order_reg[g] + FW'(1);
                    order_reg[d_idx] <= '0;
                end
            end
            if (cmd.scan_clr)
                scan_reg <= '0;
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + NW'(1);
                if (sts.scan_hit)
                begin
                    dirty_reg[scan_idx] <= 1'b0;
                    writes_reg          <= writes_reg + 32'd1;
                end
            end
            if (cmd.wipe)
            begin
                valid_reg <= '0;
                dirty_reg <= '0;
                for (int f = 0; f < FRAMES; f++)
                begin
                    page_reg[f]  <= '0;
                    pins_reg[f]  <= '0;
                    order_reg[f] <= '0;
                end
            end
        end
    end

    // Captured item and search results.
    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            c_cmd_reg      <= in_command;
            c_page_reg     <= pg_in;
            c_sel_reg      <= in_select;
            n_reg          <= n_val;
            hit_reg        <= s_hit;   hit_idx_reg    <= s_hit_i;
            empty_reg      <= s_empty; empty_idx_reg  <= s_empty_i;
            vict_reg       <= s_vict;  vict_idx_reg   <= s_vict_i;
            pinned_reg     <= s_pin;   pinned_idx_reg <= s_pin_i;
        end
    end

    // Result formatting: the output stage loads these values.
    always_comb
    begin
        r_status  = ST_OK; r_index = '0; r_page = '0; r_valid = 1'b0; r_dirty = 1'b0;
        r_pins    = '0; r_read = 1'b0; r_write = 1'b0; r_wb_page = '0; r_last = 1'b0;
        r_reads   = reads_reg;
        r_writes  = writes_reg;
        if (cmd.execute)
        begin
            r_status = d_st; r_read = d_rd; r_write = d_wr; r_last = 1'b1;
            // The write-back page is shown only with a write request.
            r_wb_page = d_wr ? 16'(d_wb) : 16'd0;
            if (d_rd) r_reads = reads_reg + 32'd1;
            if (d_wr) r_writes = writes_reg + 32'd1;
            if (d_sel)
            begin
                r_index = 4'(d_idx); r_page = 16'(nx_page); r_valid = nx_valid;
                r_dirty = nx_dirty; r_pins = nx_pins;
            end
        end
        else if (cmd.scan_step)
        begin
            r_index   = 4'(scan_idx);
            r_page    = 16'(page_reg[scan_idx]);
            r_valid   = 1'b1;
            r_pins    = pins_reg[scan_idx];
            r_write   = 1'b1;
            r_wb_page = 16'(page_reg[scan_idx]);
            r_writes  = writes_reg + 32'd1;
        end
        else if (cmd.emit_end)
            r_last = 1'b1;
    end

endmodule

FILE: sv/buffer_pool_fifo_frame_manager.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager
// Page frame pool with oldest-load replacement, pin counts and write-back.
// ----------------------------------------------------------------------------
// Usage: commands enter on the s_axis channel (tdata = command, page_number,
// frame_select), results leave on m_axis (tuser = status, tlast = last).
// The cfg channel writes frames_in_use; write it only while idle.
// A single-result command is searched in its accept cycle and the search is
// registered; the search state then applies the update and loads the result
// into the output register once it is free, which raises m_axis_tvalid.
// Flush, and shutdown with no pinned frame, clear the scan pointer and then
// scan the frames in use one per cycle, waiting at a frame whose write-back
// cannot yet enter the output register; shutdown then empties every frame,
// and the closing result is loaded last. Write-back results leave during the
// scan cycles and add nothing while the receiver keeps up.
// A new item is accepted only once the previous command has handed its
// last result to the output register.
// The output register holds a result until m_axis_tready; a write-back in the
// scan waits while it holds an untaken result. Reset empties all frames,
// clears the counters and sets frames_in_use to 16.
// ----------------------------------------------------------------------------
module buffer_pool_fifo_frame_manager
    import bpfm_pkg::*;
#(
    parameter int FRAMES    = DEF_FRAMES,
    parameter int PAGE_BITS = DEF_PAGE_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // command[2:0], page_number[18:3], frame_select[22:19]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // frame_index[3:0], frame_page[19:4], frame_valid[20],
                                         // frame_dirty[21], frame_pins[29:22], read_request[30],
                                         // write_request[31], writeback_page[47:32],
                                         // reads_total[79:48], writes_total[111:80]
    output logic [2:0]   m_axis_tuser,   // status[2:0]
    output logic         m_axis_tlast
);

    logic [4:0]  fiu_reg;
    logic        ovalid_reg;
    logic [127:0] odata_reg;
    logic [2:0]  ouser_reg;
    logic        olast_reg;

    bpfm_cmd_t   cmd;
    bpfm_sts_t   sts;
    logic        in_ready, out_load, out_free;
    logic [2:0]  r_status;
    logic [3:0]  r_index;
    logic [15:0] r_page, r_wb_page;
    logic        r_valid, r_dirty, r_read, r_write, r_last;
    logic [7:0]  r_pins;
    logic [31:0] r_reads, r_writes;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = in_ready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    bpfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && in_ready),
        .out_free (out_free),
        .sts      (sts),
        .in_ready (in_ready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    bpfm_datapath #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .frames_in_use (fiu_reg),
        .in_command    (s_axis_tdata[2:0]),
        .in_page       (s_axis_tdata[18:3]),
        .in_select     (s_axis_tdata[22:19]),
        .cmd           (cmd),
        .sts           (sts),
        .r_status      (r_status),
        .r_index       (r_index),
        .r_page        (r_page),
        .r_valid       (r_valid),
        .r_dirty       (r_dirty),
        .r_pins        (r_pins),
        .r_read        (r_read),
        .r_write       (r_write),
        .r_wb_page     (r_wb_page),
        .r_reads       (r_reads),
        .r_writes      (r_writes),
        .r_last        (r_last)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fiu_reg <= 5'd16;
        else if (cfg_valid)
            fiu_reg <= cfg_data;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (out_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            odata_reg <= {16'd0, r_writes, r_reads, r_wb_page, r_write, r_read,
                          r_pins, r_dirty, r_valid, r_page, r_index};
            ouser_reg <= r_status;
            olast_reg <= r_last;
        end
    end

endmodule

FILE: sv/bpfm_checker.sv
// ----------------------------------------------------------------------------
// Buffer pool frame manager checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpfm_checker
    import bpfm_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata))
    `CHK_IMPLY(a_status, clk, rst_n, m_axis_tvalid, m_axis_tuser <= ST_OVERFLOW)
    `CHK_IMPLY(a_multi, clk, rst_n, m_axis_tvalid && !m_axis_tlast,
               m_axis_tdata[31] && m_axis_tuser == ST_OK)
    `CHK_NEXT(a_one, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind buffer_pool_fifo_frame_manager bpfm_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
